FILE: src/tpid_pkg.sv
// Package for the timed PID controller: sequencer states, action and
// register codes, step counts and the drive clamp.
// No dependencies.
package tpid_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,   // waiting for an item
        S_MP,     // error * Kp
        S_MI1,    // error * Ki
        S_MI2,    // (error * Ki) * dt
        S_DI,     // integral increment / 256000
        S_MD1,    // delta measurement * Kd
        S_MD2,    // (delta * Kd) * 1000
        S_DD,     // derivative / (256 * dt)
        S_INT,    // integral update and clamp
        S_SUM,    // drive sum and clamp
        S_OUT     // load output register
    } t_state;

    // Action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_ON     = 2'd1;
    localparam logic [1:0] ACT_OFF    = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_KP       = 3'd0;
    localparam logic [2:0] REG_KI       = 3'd1;
    localparam logic [2:0] REG_KD       = 3'd2;
    localparam logic [2:0] REG_TARGET   = 3'd3;
    localparam logic [2:0] REG_MIN      = 3'd4;
    localparam logic [2:0] REG_MAX      = 3'd5;
    localparam logic [2:0] REG_INTERVAL = 3'd6;

    // Serial step counts
    localparam logic [6:0] CNT_GAIN  = 7'd16;
    localparam logic [6:0] CNT_TIME  = 7'd32;
    localparam logic [6:0] CNT_SCALE = 7'd10;
    localparam logic [6:0] CNT_DIV   = 7'd64;

    localparam logic [39:0] DIV_INTEGRAL = 40'd256000;  // 256 * 1000
    localparam logic [31:0] MS_PER_S     = 32'd1000;
    localparam logic [15:0] INTERVAL_RST = 16'd200;

    // Clamp: above max gives max, else below min gives min
    function automatic logic signed [15:0] clamp_drive(input logic signed [33:0] v,
                                                       input logic signed [15:0] lo,
                                                       input logic signed [15:0] hi);
        logic signed [33:0] lo_x;
        logic signed [33:0] hi_x;
        lo_x = {{18{lo[15]}}, lo};
        hi_x = {{18{hi[15]}}, hi};
        if (v > hi_x) begin
            return hi;
        end else if (v < lo_x) begin
            return lo;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

FILE: src/timed_pid_controller_unit.sv
// Timed PID controller (derivative on measurement), bit-serial datapath.
// Depends on tpid_pkg.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one item: an action
//    (sample, activate, deactivate), a signed measurement and a ms timestamp.
//  - Output channel (o_out_valid / i_out_ready) returns one result per item:
//    drive, the three terms, an updated flag and the running flag.
//  - Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//    write it only while the block is idle (the block does not enforce this).
//  - An item that computes nothing goes from acceptance straight to the output
//    state and is loaded there into the output register. A due sample runs
//    the shared shift-add multiplier and the restoring divider one bit per
//    cycle: 16 + 16 + 32 + 64 + 16 + 10 + 64 steps, then the integral, sum
//    and output states, after which the result is loaded and the next item
//    can be taken. The two 64-step divisions make up most of this work.
//  - One item is in work at a time; o_in_ready is high only when idle.
//  - The result sits in an output register; when the receiver stalls, the
//    next item may be accepted and worked on, and it waits before the
//    output load until the register is free.
//  - Reset (synchronous, active low) clears the control state and loads register
//    defaults: gains 0, target 0, limits -32768/32767, interval 200 ms.
module timed_pid_controller_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_measurement,
    input  logic [31:0]        i_now_ms,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive,
    output logic signed [31:0] o_p_term,
    output logic signed [15:0] o_i_term,
    output logic signed [31:0] o_d_term,
    output logic               o_updated,
    output logic               o_running
);
    import tpid_pkg::*;

    // configuration registers
    logic [15:0]        r_kp, r_ki, r_kd, r_interval;
    logic signed [15:0] r_target, r_dmin, r_dmax;

    // controller state
    logic signed [15:0] r_iacc, r_prev, r_drive;
    logic signed [31:0] r_phold, r_dhold;
    logic [31:0]        r_last;
    logic               r_primed, r_active;

    // item in work
    logic signed [15:0] r_meas;
    logic [31:0]        r_now, r_dt;
    logic               r_eneg, r_dneg, r_upd;
    logic [15:0]        r_emag, r_dmag;

    // serial datapath
    logic [63:0]        r_mc, r_prod;
    logic [31:0]        r_mq;
    logic [39:0]        r_rem, r_dvs;
    logic [6:0]         r_cnt;
    logic [17:0]        r_incmag;

    // output register
    logic               r_ovalid, r_oupd, r_orun;
    logic signed [15:0] r_odrive, r_oiterm;
    logic signed [31:0] r_opterm, r_odterm;

    t_state r_state, n_state;
    logic   in_acc, out_load, go, last_step;

    // error, measurement delta and elapsed time at acceptance
    logic signed [16:0] e_val, dm_val;
    logic [16:0]        e_abs, dm_abs;
    logic [31:0]        dt_val;
    logic               due;

    assign e_val  = {r_target[15], r_target} - {i_measurement[15], i_measurement};
    assign dm_val = {r_prev[15], r_prev} - {i_measurement[15], i_measurement};
    assign e_abs  = e_val[16] ? -e_val : e_val;
    assign dm_abs = dm_val[16] ? -dm_val : dm_val;
    assign dt_val = r_primed ? (i_now_ms - r_last) : {16'd0, r_interval};
    assign due    = dt_val >= {16'd0, r_interval};

    assign in_acc    = i_in_valid && o_in_ready;
    assign go        = (i_action == ACT_SAMPLE) && r_active && due;
    assign last_step = (r_cnt == 7'd1);

    // multiply step: add shifted multiplicand when multiplier bit is set
    logic [63:0] mul_sum;
    assign mul_sum = r_prod + (r_mq[0] ? r_mc : 64'd0);

    // divide step: restoring, quotient bits shift into r_prod
    logic [40:0] div_t, div_diff;
    logic        div_ge;
    assign div_t    = {r_rem, r_prod[63]};
    assign div_ge   = div_t >= {1'b0, r_dvs};
    assign div_diff = div_t - {1'b0, r_dvs};

    // derivative divisor: 256 * dt, with dt of zero taken as one
    logic [31:0] dtd;
    assign dtd = (r_dt == 32'd0) ? 32'd1 : r_dt;

    // saturated derivative from the final quotient
    logic        d_neg_big, d_pos_big;
    logic [31:0] d_sat;
    assign d_neg_big = (|r_prod[63:32]) || (r_prod[31] && (|r_prod[30:0]));
    assign d_pos_big = |r_prod[63:31];
    always_comb begin
        if (r_dneg) begin
            d_sat = d_neg_big ? 32'h8000_0000 : -r_prod[31:0];
        end else begin
            d_sat = d_pos_big ? 32'h7FFF_FFFF : r_prod[31:0];
        end
    end

    // integral update and drive sum
    logic signed [19:0] inc_s, iacc_sum;
    logic signed [33:0] drive_sum;
    assign inc_s     = r_eneg ? -{2'b00, r_incmag} : {2'b00, r_incmag};
    assign iacc_sum  = {{4{r_iacc[15]}}, r_iacc} + inc_s;
    assign drive_sum = {{2{r_phold[31]}}, r_phold} + {{18{r_iacc[15]}}, r_iacc}
                     + {{2{r_dhold[31]}}, r_dhold};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = go ? S_MP : S_OUT;
            S_MP:    if (last_step) n_state = S_MI1;
            S_MI1:   if (last_step) n_state = S_MI2;
            S_MI2:   if (last_step) n_state = S_DI;
            S_DI:    if (last_step) n_state = S_MD1;
            S_MD1:   if (last_step) n_state = S_MD2;
            S_MD2:   if (last_step) n_state = S_DD;
            S_DD:    if (last_step) n_state = S_INT;
            S_INT:   n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_OUT:   out_load = !r_ovalid || i_out_ready;
            default: ;
        endcase
    end

    // control state, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_target   <= '0;
            r_dmin     <= 16'sh8000;
            r_dmax     <= 16'sh7FFF;
            r_interval <= INTERVAL_RST;
            r_iacc     <= '0;
            r_prev     <= '0;
            r_drive    <= '0;
            r_phold    <= '0;
            r_dhold    <= '0;
            r_last     <= '0;
            r_primed   <= 1'b0;
            r_active   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_upd      <= 1'b0;
        end else begin
            // configuration writes; limit writes re-clamp the drive
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KP:       r_kp <= i_cfg_data;
                    REG_KI:       r_ki <= i_cfg_data;
                    REG_KD:       r_kd <= i_cfg_data;
                    REG_TARGET:   r_target <= i_cfg_data;
                    REG_MIN: begin
                        r_dmin  <= i_cfg_data;
                        r_drive <= clamp_drive({{18{r_drive[15]}}, r_drive},
                                               i_cfg_data, r_dmax);
                    end
                    REG_MAX: begin
                        r_dmax  <= i_cfg_data;
                        r_drive <= clamp_drive({{18{r_drive[15]}}, r_drive},
                                               r_dmin, i_cfg_data);
                    end
                    REG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end

            // item acceptance: events and the due decision
            if (in_acc) begin
                r_upd <= go;
                case (i_action)
                    ACT_ON: begin
                        if (!r_active) begin
                            r_iacc <= clamp_drive({{18{r_drive[15]}}, r_drive},
                                                  r_dmin, r_dmax);
                            r_prev <= i_measurement;
                        end
                        r_active <= 1'b1;
                    end
                    ACT_OFF: r_active <= 1'b0;
                    default: ;
                endcase
            end

            // committed results
            if (r_state == S_MP && last_step) begin
                r_phold <= r_eneg ? -{8'd0, mul_sum[31:8]} : {8'd0, mul_sum[31:8]};
            end
            // the derivative quotient is complete once the division has ended
            if (r_state == S_INT) begin
                r_dhold <= d_sat;
                r_iacc  <= clamp_drive({{14{iacc_sum[19]}}, iacc_sum}, r_dmin, r_dmax);
            end
            if (r_state == S_SUM) begin
                r_drive  <= clamp_drive(drive_sum, r_dmin, r_dmax);
                r_prev   <= r_meas;
                r_last   <= r_now;
                r_primed <= 1'b1;
            end

            // output valid
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // serial datapath and item payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_meas <= i_measurement;
            r_now  <= i_now_ms;
            r_dt   <= dt_val;
            r_eneg <= e_val[16];
            r_dneg <= dm_val[16];
            r_emag <= e_abs[15:0];
            r_dmag <= dm_abs[15:0];
            // first product: |e| * Kp
            r_mc   <= {48'd0, e_abs[15:0]};
            r_mq   <= {16'd0, r_kp};
            r_prod <= '0;
            r_cnt  <= CNT_GAIN;
        end

        unique case (r_state)
            S_MP, S_MI1, S_MI2, S_MD1, S_MD2: begin
                r_prod <= mul_sum;
                r_mc   <= {r_mc[62:0], 1'b0};
                r_mq   <= {1'b0, r_mq[31:1]};
                r_cnt  <= r_cnt - 7'd1;
                if (last_step) begin
                    unique case (r_state)
                        S_MP: begin
                            r_mc   <= {48'd0, r_emag};
                            r_mq   <= {16'd0, r_ki};
                            r_prod <= '0;
                            r_cnt  <= CNT_GAIN;
                        end
                        S_MI1: begin
                            r_mc   <= mul_sum;
                            r_mq   <= r_dt;
                            r_prod <= '0;
                            r_cnt  <= CNT_TIME;
                        end
                        S_MI2: begin
                            r_rem <= '0;
                            r_dvs <= DIV_INTEGRAL;
                            r_cnt <= CNT_DIV;
                        end
                        S_MD1: begin
                            r_mc   <= mul_sum;
                            r_mq   <= MS_PER_S;
                            r_prod <= '0;
                            r_cnt  <= CNT_SCALE;
                        end
                        default: begin
                            r_rem <= '0;
                            r_dvs <= {dtd, 8'd0};
                            r_cnt <= CNT_DIV;
                        end
                    endcase
                end
            end
            S_DI, S_DD: begin
                r_rem  <= div_ge ? div_diff[39:0] : div_t[39:0];
                r_prod <= {r_prod[62:0], div_ge};
                r_cnt  <= r_cnt - 7'd1;
                if (r_state == S_DI && last_step) begin
                    // increment magnitude, saturated past any clamp range
                    r_incmag <= (|r_prod[62:16]) ? 18'h2_0000
                                                 : {1'b0, r_prod[15:0], div_ge};
                    r_mc     <= {48'd0, r_dmag};
                    r_mq     <= {16'd0, r_kd};
                    r_prod   <= '0;
                    r_cnt    <= CNT_GAIN;
                end
            end
            default: ;
        endcase

        // output register payload
        if (out_load) begin
            r_odrive <= r_drive;
            r_opterm <= r_phold;
            r_oiterm <= r_iacc;
            r_odterm <= r_dhold;
            r_oupd   <= r_upd;
            r_orun   <= r_active;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_drive     = r_odrive;
    assign o_p_term    = r_opterm;
    assign o_i_term    = r_oiterm;
    assign o_d_term    = r_odterm;
    assign o_updated   = r_oupd;
    assign o_running   = r_orun;

    // a sample while inactive computes nothing
    a_idle_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == ACT_SAMPLE && !r_active) |=> (r_state == S_OUT))
        else $error("inactive sample started a computation");

    // an update is only reported while running
    a_upd_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_upd) |-> r_active)
        else $error("update flagged while inactive");

    // with ordered limits the drive stays inside them
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dmin <= r_dmax) |-> (r_drive >= r_dmin && r_drive <= r_dmax))
        else $error("drive outside limits");

endmodule

FILE: sim/timed_pid_controller_unit_tb.sv
// Testbench for timed_pid_controller_unit: a directed table, then random phases,
// all checked item by item against a behavioral PID model or typed expected results.
// Depends on tpid_pkg and timed_pid_controller_unit.
`timescale 1ns / 1ps

module timed_pid_controller_unit_tb;
    import tpid_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         RANDOM_ITEMS = 1300;
    localparam int         HOLD_AT_ITEM = 500;
    localparam int         HOLD_CYCLES = 2500;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [31:0] p_term;
        logic signed [15:0] i_term;
        logic signed [31:0] d_term;
        logic               updated;
        logic               running;
    } pid_out_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [15:0] data;
        logic [1:0]  action;
        logic [15:0] meas;
        logic [31:0] now;
        bit          typed;
        pid_out_t    result;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_action = '0;
    logic signed [15:0] i_measurement = '0;
    logic [31:0]        i_now_ms = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_drive;
    logic signed [31:0] o_p_term;
    logic signed [15:0] o_i_term;
    logic signed [31:0] o_d_term;
    logic               o_updated;
    logic               o_running;

    timed_pid_controller_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Model state and registers
    longint unsigned m_kp, m_ki, m_kd, m_interval, m_last;
    longint          m_target, m_min, m_max;
    longint          m_integral, m_prev, m_drive, m_p, m_d;
    bit              m_primed, m_active;

    pid_out_t  pending_results[$];
    stim_row_t stim_table[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        cycles = 0;
    int        burst_left = 0;

    function automatic longint clamp_lim(longint v);
        if (v > m_max) return m_max;
        if (v < m_min) return m_min;
        return v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void model_reset();
        m_kp = 0; m_ki = 0; m_kd = 0; m_target = 0;
        m_min = -32768; m_max = 32767; m_interval = 200;
        m_integral = 0; m_prev = 0; m_drive = 0; m_p = 0; m_d = 0;
        m_last = 0; m_primed = 0; m_active = 0;
    endfunction

    function automatic void model_cfg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            REG_KP:       m_kp = data;
            REG_KI:       m_ki = data;
            REG_KD:       m_kd = data;
            REG_TARGET:   m_target = longint'(signed'(data));
            REG_MIN: begin
                m_min = longint'(signed'(data));
                m_drive = clamp_lim(m_drive);
            end
            REG_MAX: begin
                m_max = longint'(signed'(data));
                m_drive = clamp_lim(m_drive);
            end
            REG_INTERVAL: m_interval = data;
            default: ;
        endcase
    endfunction

    // PID step: returns the result this item produces
    function automatic pid_out_t pid_step(logic [1:0] act, logic signed [15:0] meas,
                                          logic [31:0] now);
        pid_out_t        r;
        logic [31:0]     dt;
        longint unsigned dtl, dtd, emag, dmag, q;
        longint          e, dm, inc, p, d;
        bit              upd;
        upd = 0;
        if (act == ACT_ON) begin
            if (!m_active) begin
                m_integral = clamp_lim(m_drive);
                m_prev = meas;
            end
            m_active = 1;
        end else if (act == ACT_OFF) begin
            m_active = 0;
        end else if (act == ACT_SAMPLE && m_active) begin
            dt = m_primed ? now - m_last[31:0] : m_interval[31:0];
            dtl = dt;
            if (dtl >= m_interval) begin
                e = m_target - longint'(meas);
                emag = (e < 0) ? -e : e;
                dm = m_prev - longint'(meas);
                dmag = (dm < 0) ? -dm : dm;
                dtd = (dtl == 0) ? 1 : dtl;
                q = emag * m_kp / 256;
                p = sat32((e < 0) ? -longint'(q) : longint'(q));
                q = emag * m_ki * dtl / 256000;
                inc = (e < 0) ? -longint'(q) : longint'(q);
                m_integral = clamp_lim(m_integral + inc);
                q = dmag * m_kd * 1000 / (256 * dtd);
                d = sat32((dm < 0) ? -longint'(q) : longint'(q));
                m_drive = clamp_lim(p + m_integral + d);
                m_p = p; m_d = d; m_prev = meas; m_last = now;
                m_primed = 1; upd = 1;
            end
        end
        r.drive = m_drive[15:0];
        r.p_term = m_p[31:0];
        r.i_term = m_integral[15:0];
        r.d_term = m_d[31:0];
        r.updated = upd;
        r.running = m_active;
        return r;
    endfunction

    // Table helpers
    task automatic row_cfg(logic [2:0] idx, logic [15:0] data);
        stim_row_t s;
        s = '{default: '0};
        s.is_cfg = 1; s.idx = idx; s.data = data;
        stim_table.push_back(s);
    endtask

    task automatic row_item(logic [1:0] act, logic [15:0] meas, logic [31:0] now,
                            bit typed = 0, pid_out_t res = '0);
        stim_row_t s;
        s = '{default: '0};
        s.action = act; s.meas = meas; s.now = now; s.typed = typed; s.result = res;
        stim_table.push_back(s);
    endtask

    // Wait until every result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One write, then the write enable drops before the next
    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        model_cfg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item; the sender sends in bursts with idle gaps between them
    task automatic send_item(logic [1:0] act, logic [15:0] meas, logic [31:0] now,
                             bit typed, pid_out_t res);
        pid_out_t predicted;
        int       gap;
        i_in_valid <= 1'b1; i_action <= act; i_measurement <= meas; i_now_ms <= now;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = pid_step(act, meas, now);
        pending_results.push_back(typed ? res : predicted);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 30);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver: stall pattern, with one long hold-off
    initial begin : receiver
        int  hold_left;
        bit  held;
        int  mode_cnt;
        hold_left = 0; held = 0; mode_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= HOLD_AT_ITEM) begin
                held = 1;
                hold_left = HOLD_CYCLES;
            end
            mode_cnt = (mode_cnt + 1) % 600;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (mode_cnt < 200) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Result check
    always @(posedge i_clk) begin
        pid_out_t want;
        pid_out_t got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_drive, o_p_term, o_i_term, o_d_term, o_updated, o_running};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : main
        stim_row_t   s;
        logic [31:0] now;
        logic [15:0] meas;
        logic [15:0] lo, hi;
        int          phase_len, k, sel, n;
        pid_out_t    zero_idle, zero_run, first_upd;

        zero_idle = '0;
        zero_run = '0; zero_run.running = 1;
        first_upd = zero_run; first_upd.updated = 1;

        // Directed table
        row_item(ACT_SAMPLE, 16'sd100, 32'd0, 1, zero_idle);     // sample while inactive
        row_item(ACT_UNUSED, 16'h7fff, 32'hffff_ffff, 1, zero_idle);   // unused action code
        row_item(ACT_OFF, 16'h8000, 32'd5, 1, zero_idle);
        row_item(ACT_ON, 16'sd0, 32'd10, 1, zero_run);
        row_item(ACT_ON, 16'h8000, 32'd11, 1, zero_run);         // activate while active
        row_item(ACT_SAMPLE, 16'sd0, 32'd12, 1, first_upd);      // first sample is due
        row_cfg(REG_KP, 16'hffff);
        row_cfg(REG_KI, 16'hffff);
        row_cfg(REG_KD, 16'hffff);
        row_cfg(REG_TARGET, 16'h7fff);
        row_cfg(REG_INTERVAL, 16'd1);
        row_item(ACT_SAMPLE, 16'h8000, 32'd13, 0);               // largest error
        row_item(ACT_SAMPLE, 16'h7fff, 32'd13, 0);               // not due
        row_item(ACT_SAMPLE, 16'h7fff, 32'hffff_fff0, 0);        // huge dt
        row_item(ACT_SAMPLE, 16'h8000, 32'h0000_0003, 0);        // time wraps
        row_cfg(REG_UNUSED, 16'h1234);
        row_cfg(REG_MIN, 16'sd100);                               // inverted limits
        row_cfg(REG_MAX, -16'sd100);
        row_item(ACT_SAMPLE, 16'sd5, 32'd10, 0);
        row_cfg(REG_MIN, 16'h8000);
        row_cfg(REG_MAX, 16'h7fff);
        row_cfg(REG_INTERVAL, 16'd0);                             // zero elapsed time
        row_item(ACT_SAMPLE, 16'sd7, 32'd10, 0);
        row_item(ACT_OFF, 16'sd0, 32'd11, 0);
        row_item(ACT_ON, 16'h8000, 32'd12, 0);
        row_cfg(REG_INTERVAL, 16'hffff);
        row_item(ACT_SAMPLE, 16'h7fff, 32'd65546, 0);
        row_item(ACT_SAMPLE, 16'h7fff, 32'd65547, 0);

        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[j]) begin
            s = stim_table[j];
            if (s.is_cfg) begin
                drain();
                write_reg(s.idx, s.data);
            end else begin
                send_item(s.action, s.meas, s.now, s.typed, s.result);
            end
        end

        // Random phases, each with fresh settings
        now = $urandom;
        meas = 16'($urandom);
        n = 0;
        while (n < RANDOM_ITEMS) begin
            drain();
            for (int r = 0; r < 3; r++) begin
                sel = $urandom_range(0, 7);
                write_reg(r[2:0], sel == 0 ? 16'd0 : sel == 1 ? 16'hffff :
                                  sel < 5 ? 16'($urandom_range(0, 1024)) : 16'($urandom));
            end
            write_reg(REG_TARGET, $urandom_range(0, 5) == 0 ? 16'($urandom)
                                                              : 16'($urandom_range(0, 4000)));
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                lo = 16'h8000; hi = 16'h7fff;
            end else if (sel == 1) begin
                lo = 16'($urandom); hi = 16'($urandom);             // may be inverted
            end else begin
                lo = -16'($urandom_range(0, 20000));
                hi = 16'($urandom_range(0, 20000));
            end
            write_reg(REG_MIN, lo);
            write_reg(REG_MAX, hi);
            sel = $urandom_range(0, 9);
            write_reg(REG_INTERVAL, sel == 0 ? 16'd1 : sel == 1 ? 16'hffff :
                                    16'($urandom_range(1, 1000)));
            send_item(ACT_ON, meas, now, 0, '0);
            n++;
            phase_len = $urandom_range(60, 140);
            for (k = 0; k < phase_len; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    now = now + 32'(m_interval) + $urandom_range(0, 32'(m_interval));
                else if (sel < 92)
                    now = now + $urandom_range(0, 32'(m_interval));
                else
                    now = $urandom;
                meas = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : meas + 16'($urandom_range(0, 400)) - 16'd200;
                sel = $urandom_range(0, 99);
                send_item(sel < 4 ? ACT_OFF : sel < 9 ? ACT_ON : sel < 10 ? ACT_UNUSED
                                                                           : ACT_SAMPLE,
                          meas, now, 0, '0);
                n++;
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: timed_pid_controller_unit.f
src/tpid_pkg.sv
src/timed_pid_controller_unit.sv
sim/timed_pid_controller_unit_tb.sv
